@@ design/sde_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sde_pkg
// Shared types, constants and microcode ROM of the spike delta encoder.
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int SDE_SLICE_COUNT     = 8;
  localparam int SDE_WORD_BITS       = 32;
  localparam int SDE_MAX_WORDS_LOG2  = 6;
  localparam int SDE_POS_BITS        = 35;
  localparam int SDE_CARRY_BITS      = 38;
  localparam int SDE_ACC_BITS        = 39;

  localparam logic [SDE_CARRY_BITS-1:0] CARRY_MAX = '1;

  localparam logic [1:0] MODE_SPIKE = 2'd0;
  localparam logic [1:0] MODE_EOG   = 2'd1;
  localparam logic [1:0] MODE_TERM  = 2'd2;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_POS,
    ST_SUM,
    ST_CMP,
    ST_CLIP,
    ST_EMIT,
    ST_OERR,
    ST_EOG,
    ST_TERM
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_POS,
    OP_SUM,
    OP_CMP,
    OP_CLIP,
    OP_EMIT,
    OP_OERR,
    OP_EOG,
    OP_TERM
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_ORDER,
    C_EMIT,
    C_FREE
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] mode;
    logic       order_lt;
    logic       out_free;
    logic       acc_ge_esc;
  } status_t;

  function automatic uword_t sde_rom(step_t s);
    uword_t w;
    w = '{in_rdy: 1'b0, op: OP_NOP, cond: C_JUMP, target: ST_FETCH};
    case (s)
      ST_FETCH: w = '{in_rdy: 1'b1, op: OP_LOAD, cond: C_DISPATCH, target: ST_FETCH};
      ST_POS:   w = '{in_rdy: 1'b0, op: OP_POS,  cond: C_NEXT,     target: ST_FETCH};
      ST_SUM:   w = '{in_rdy: 1'b0, op: OP_SUM,  cond: C_NEXT,     target: ST_FETCH};
      ST_CMP:   w = '{in_rdy: 1'b0, op: OP_CMP,  cond: C_ORDER,    target: ST_OERR};
      ST_CLIP:  w = '{in_rdy: 1'b0, op: OP_CLIP, cond: C_NEXT,     target: ST_FETCH};
      ST_EMIT:  w = '{in_rdy: 1'b0, op: OP_EMIT, cond: C_EMIT,     target: ST_FETCH};
      ST_OERR:  w = '{in_rdy: 1'b0, op: OP_OERR, cond: C_FREE,     target: ST_FETCH};
      ST_EOG:   w = '{in_rdy: 1'b0, op: OP_EOG,  cond: C_JUMP,     target: ST_FETCH};
      ST_TERM:  w = '{in_rdy: 1'b0, op: OP_TERM, cond: C_JUMP,     target: ST_CLIP};
      default:  w = '{in_rdy: 1'b0, op: OP_NOP,  cond: C_JUMP,     target: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ design/sde_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sde_seq
// Step counter and microcode ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module sde_seq
  import sde_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t st,
  output uword_t       uw
);

  step_t step;
  step_t step_next;

  always_comb begin
    uw = sde_rom(step);
  end

  always_comb begin
    step_next = step;
    case (uw.cond)
      C_NEXT: step_next = step_t'(4'(step) + 4'd1);
      C_JUMP: step_next = uw.target;
      C_DISPATCH: begin
        if (st.accept) begin
          case (st.mode)
            MODE_SPIKE: step_next = ST_POS;
            MODE_EOG:   step_next = ST_EOG;
            MODE_TERM:  step_next = ST_TERM;
            default:    step_next = ST_FETCH;
          endcase
        end
      end
      C_ORDER: step_next = st.order_lt ? uw.target : step_t'(4'(step) + 4'd1);
      C_EMIT: begin
        if (st.out_free && !st.acc_ge_esc) begin
          step_next = uw.target;
        end
      end
      C_FREE: begin
        if (st.out_free) begin
          step_next = uw.target;
        end
      end
      default: step_next = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

@@ design/spike_delta_encoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spike_delta_encoder_top
// Delta-encodes sorted spike positions into escape and delta words.
// ----------------------------------------------------------------------------
// Spike: load, position, sum, compare, clip and emit steps; emit gives one word per
//   cycle while the output is free, and the next item is taken after the last word.
// End of group: no words. Terminate: the carry is clipped and emitted as words.
// Order error: one word. The microcode step counter sets the pace.
// Reset clears carry, last position and group flag at once; no clearing pass.
module spike_delta_encoder_top
  import sde_pkg::*;
#(
  parameter int SLICE_COUNT = SDE_SLICE_COUNT,
  parameter int WORD_BITS   = SDE_WORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] neuron_id,
  input  wire logic [2:0]  slice,
  input  wire logic [31:0] group_size,
  output logic             word_valid,
  input  wire logic        word_stall,
  output logic [31:0]      word,
  output logic             last,
  output logic             escape,
  output logic             saturated,
  output logic             order_error
);

  localparam logic [SDE_ACC_BITS-1:0] ESC =
    (SDE_ACC_BITS'(1) << WORD_BITS) - SDE_ACC_BITS'(1);
  localparam logic [SDE_ACC_BITS-1:0] LIMIT =
    (ESC << SDE_MAX_WORDS_LOG2) - SDE_ACC_BITS'(1);

  uword_t  uw;
  status_t st;

  logic [SDE_CARRY_BITS-1:0] carry;
  logic [SDE_POS_BITS-1:0]   last_position;
  logic                      group_has_spike;

  logic [31:0]               nid;
  logic [2:0]                slc;
  logic [31:0]               gsize;
  logic [SDE_POS_BITS-1:0]   pos;
  logic [SDE_ACC_BITS-1:0]   acc;
  logic                      sat;

  logic [SDE_POS_BITS-1:0]   prod;
  logic [SDE_POS_BITS-1:0]   span;
  logic [SDE_ACC_BITS-1:0]   carry_sum;
  logic [SDE_CARRY_BITS-1:0] carry_next;
  logic                      out_free;

  sde_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .uw  (uw)
  );

  assign item_stall = !uw.in_rdy;
  assign out_free   = !word_valid || !word_stall;

  always_comb begin
    st.accept     = item_valid && uw.in_rdy;
    st.mode       = mode;
    st.order_lt   = acc < SDE_ACC_BITS'(last_position);
    st.out_free   = out_free;
    st.acc_ge_esc = acc >= ESC;
  end

  always_comb begin
    prod      = SDE_POS_BITS'(slc) * SDE_POS_BITS'(gsize);
    span      = SDE_POS_BITS'(gsize) * SDE_POS_BITS'(SLICE_COUNT);
    carry_sum = SDE_ACC_BITS'(carry) + SDE_ACC_BITS'(span);
    if (group_has_spike) begin
      carry_next = (span >= last_position) ?
                   SDE_CARRY_BITS'(span - last_position) : '0;
    end else if (carry_sum > SDE_ACC_BITS'(CARRY_MAX)) begin
      carry_next = CARRY_MAX;
    end else begin
      carry_next = carry_sum[SDE_CARRY_BITS-1:0];
    end
  end

  // control and encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid      <= 1'b0;
      carry           <= '0;
      last_position   <= '0;
      group_has_spike <= 1'b0;
    end else begin
      if ((uw.op inside {OP_EMIT, OP_OERR}) && out_free) begin
        word_valid <= 1'b1;
      end else if (word_valid && !word_stall) begin
        word_valid <= 1'b0;
      end
      case (uw.op)
        OP_CMP: begin
          last_position   <= pos;
          carry           <= '0;
          group_has_spike <= 1'b1;
        end
        OP_EOG: begin
          carry           <= carry_next;
          last_position   <= '0;
          group_has_spike <= 1'b0;
        end
        OP_TERM: begin
          carry           <= '0;
          last_position   <= '0;
          group_has_spike <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath and output beat registers
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (st.accept) begin
          nid   <= neuron_id;
          slc   <= slice;
          gsize <= group_size;
        end
      end
      OP_POS: pos <= prod + SDE_POS_BITS'(nid);
      OP_SUM: acc <= SDE_ACC_BITS'(pos) + SDE_ACC_BITS'(carry);
      OP_CMP: begin
        if (!st.order_lt) begin
          acc <= acc - SDE_ACC_BITS'(last_position);
        end
        sat <= 1'b0;
      end
      OP_CLIP: begin
        if (acc > LIMIT) begin
          acc <= LIMIT;
          sat <= 1'b1;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          if (st.acc_ge_esc) begin
            word   <= ESC[31:0];
            last   <= 1'b0;
            escape <= 1'b1;
            acc    <= acc - ESC;
          end else begin
            word   <= acc[31:0];
            last   <= 1'b1;
            escape <= 1'b0;
          end
          saturated   <= sat;
          order_error <= 1'b0;
        end
      end
      OP_OERR: begin
        if (out_free) begin
          word        <= '0;
          last        <= 1'b1;
          escape      <= 1'b0;
          saturated   <= 1'b0;
          order_error <= 1'b1;
        end
      end
      OP_TERM: begin
        acc <= SDE_ACC_BITS'(carry);
        sat <= (carry == CARRY_MAX);
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_clipped: assert property (@(posedge clk) disable iff (rst)
    uw.op == OP_EMIT |-> acc <= LIMIT)
    else $error("emit value above clip limit");

  a_oerr_word: assert property (@(posedge clk) disable iff (rst)
    word_valid && order_error |-> word == '0 && last && !escape)
    else $error("order error beat malformed");

  a_escape_more: assert property (@(posedge clk) disable iff (rst)
    word_valid && escape |-> uw.op == OP_EMIT && !last)
    else $error("escape beat without a following word");
`endif

endmodule
`default_nettype wire
